FILE: design/assert_macros.svh
// Assertion macros used by the port checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the clock cycle after the antecedent.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/rope_pkg.sv
// ----------------------------------------------------------------------------
// Rotary embedding package
// Shared widths, status codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package rope_pkg;

  localparam int FreqW = 40;
  localparam int SampW = 16;
  localparam int PosW = 16;
  localparam int IdxW = 6;
  localparam int PairW = 7;
  localparam int GuardBits = 14;
  localparam int DataW = 36;
  localparam int AngW = 33;
  localparam int AtanLen = 24;
  localparam logic signed [31:0] GainQ30 = 32'sd652032874;

  typedef logic [1:0] status_t;
  localparam status_t StatusOk = 2'd0;
  localparam status_t StatusRange = 2'd1;
  localparam status_t StatusLoad = 2'd2;

  typedef logic signed [DataW-1:0] data_t;
  typedef logic signed [AngW-1:0] ang_t;

  typedef struct packed {
    logic rot;
    status_t status;
  } tag_t;

  function automatic ang_t atan_turns(input int i);
    logic [31:0] v;
    case (i)
      0: v = 32'h20000000;
      1: v = 32'h12E4051E;
      2: v = 32'h09FB385B;
      3: v = 32'h051111D4;
      4: v = 32'h028B0D43;
      5: v = 32'h0145D7E1;
      6: v = 32'h00A2F61E;
      7: v = 32'h00517C55;
      8: v = 32'h0028BE53;
      9: v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return ang_t'({1'b0, v});
  endfunction

endpackage

FILE: design/rotary_position_embedding_core.sv
// Stages: read, product, fold, CORDIC_STAGES (max 24) rotations, gain, output.
// Throughput: one beat per cycle; a stall freezes the whole pipeline.
// The frequency table is a one-port memory with a registered read.
// Reset clears the pipeline valids and sets pairs_in_use to 64.
// Table contents are undefined after reset until loaded.
// ----------------------------------------------------------------------------
// Rotary position embedding core
// Table lookup, angle multiply, quadrant fold, CORDIC, gain and saturation.
// ----------------------------------------------------------------------------
module rotary_position_embedding_core #(
  parameter int MAX_PAIRS = 64,
  parameter int CORDIC_STAGES = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [rope_pkg::PairW-1:0] cfg_wdata,
  input  logic in_valid,
  output logic in_stall,
  input  logic req_type,
  input  logic [rope_pkg::IdxW-1:0] pair_index,
  input  logic [rope_pkg::PosW-1:0] position,
  input  logic signed [rope_pkg::SampW-1:0] x_even,
  input  logic signed [rope_pkg::SampW-1:0] x_odd,
  input  logic [rope_pkg::FreqW-1:0] freq_value,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [rope_pkg::SampW-1:0] y_even,
  output logic signed [rope_pkg::SampW-1:0] y_odd,
  output rope_pkg::status_t status
);
  import rope_pkg::*;

  localparam int NStg = (CORDIC_STAGES > AtanLen) ? AtanLen : CORDIC_STAGES;
  localparam int AddrW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;

  logic en;
  logic [PairW-1:0] pairs_in_use;
  logic [FreqW-1:0] mem [MAX_PAIRS];

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      pairs_in_use <= PairW'(64);
    end else if (cfg_we) begin
      pairs_in_use <= cfg_wdata;
    end
  end

  logic acc;
  logic in_map;
  logic [AddrW-1:0] addr;
  assign acc = in_valid && en;
  assign in_map = ({{(32-IdxW){1'b0}}, pair_index} < MAX_PAIRS);
  assign addr = AddrW'(pair_index);

  // Stage 1: memory read.
  logic v1;
  tag_t t1;
  logic [PosW-1:0] p1;
  logic signed [SampW-1:0] e1, o1;
  logic [FreqW-1:0] f1;

  always_ff @(posedge clk) begin
    if (acc && !req_type && in_map) begin
      mem[addr] <= freq_value;
    end
    if (en) begin
      f1 <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= position;
      e1 <= x_even;
      o1 <= x_odd;
      if (!req_type) begin
        t1 <= '{rot: 1'b0, status: StatusLoad};
      end else if ({1'b0, pair_index} >= pairs_in_use || !in_map) begin
        t1 <= '{rot: 1'b0, status: StatusRange};
      end else begin
        t1 <= '{rot: 1'b1, status: StatusOk};
      end
    end
  end

  // Stage 2: phase product, fractional 40 bits kept.
  logic v2;
  tag_t t2;
  logic signed [SampW-1:0] e2, o2;
  logic [FreqW-1:0] ph2;
  logic [FreqW+PosW-1:0] prod;
  assign prod = f1 * p1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t2 <= t1;
      e2 <= e1;
      o2 <= o1;
      ph2 <= prod[FreqW-1:0];
    end
  end

  // Stage 3: quadrant fold.
  logic [31:0] phase;
  logic [1:0] quad;
  logic [31:0] zr;
  logic signed [SampW:0] xs, ys;
  assign phase = ph2[FreqW-1:8];
  assign quad = 2'(({1'b0, phase} + 33'h20000000) >> 30);
  assign zr = phase - {quad, 30'd0};

  always_comb begin
    case (quad)
      2'd1: begin
        xs = -$signed({o2[SampW-1], o2});
        ys = {e2[SampW-1], e2};
      end
      2'd2: begin
        xs = -$signed({e2[SampW-1], e2});
        ys = -$signed({o2[SampW-1], o2});
      end
      2'd3: begin
        xs = {o2[SampW-1], o2};
        ys = -$signed({e2[SampW-1], e2});
      end
      default: begin
        xs = {e2[SampW-1], e2};
        ys = {o2[SampW-1], o2};
      end
    endcase
  end

  logic cv [NStg+1];
  data_t cx [NStg+1];
  data_t cy [NStg+1];
  ang_t cz [NStg+1];
  tag_t ct [NStg+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (en) begin
      cv[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ct[0] <= t2;
      cx[0] <= data_t'(xs) <<< GuardBits;
      cy[0] <= data_t'(ys) <<< GuardBits;
      cz[0] <= ang_t'($signed(zr));
    end
  end

  for (genvar g = 0; g < NStg; g++) begin : g_stage
    rope_cordic_stage #(.Shift(g)) u_stage (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(cv[g]), .in_x(cx[g]), .in_y(cy[g]), .in_z(cz[g]), .in_tag(ct[g]),
      .out_valid(cv[g+1]), .out_x(cx[g+1]), .out_y(cy[g+1]), .out_z(cz[g+1]),
      .out_tag(ct[g+1])
    );
  end

  // Gain multiply.
  logic vg;
  tag_t tg;
  logic signed [DataW+31:0] gx, gy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vg <= 1'b0;
    end else if (en) begin
      vg <= cv[NStg];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tg <= ct[NStg];
      gx <= cx[NStg] * GainQ30;
      gy <= cy[NStg] * GainQ30;
    end
  end

  // Round, saturate and output register.
  localparam logic signed [DataW+31:0] Rnd = (DataW+32)'(1) <<< (29 + GuardBits);

  function automatic logic signed [SampW-1:0] sat(input logic signed [DataW+31:0] v);
    logic signed [DataW+31:0] r;
    r = (v + Rnd) >>> (30 + GuardBits);
    if (r > 32767) return 16'sh7FFF;
    if (r < -32768) return -16'sh8000;
    return r[SampW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vg;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      status <= tg.status;
      y_even <= tg.rot ? sat(gx) : '0;
      y_odd <= tg.rot ? sat(gy) : '0;
    end
  end
endmodule

FILE: design/rope_cordic_stage.sv
// ----------------------------------------------------------------------------
// Rotary embedding CORDIC stage
// One registered micro-rotation with a fixed shift and a carried tag.
// ----------------------------------------------------------------------------
module rope_cordic_stage #(
  parameter int Shift = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  rope_pkg::data_t in_x,
  input  rope_pkg::data_t in_y,
  input  rope_pkg::ang_t in_z,
  input  rope_pkg::tag_t in_tag,
  output logic out_valid,
  output rope_pkg::data_t out_x,
  output rope_pkg::data_t out_y,
  output rope_pkg::ang_t out_z,
  output rope_pkg::tag_t out_tag
);
  import rope_pkg::*;

  data_t x_sh;
  data_t y_sh;
  ang_t a;

  assign x_sh = in_x >>> Shift;
  assign y_sh = in_y >>> Shift;
  assign a = atan_turns(Shift);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tag <= in_tag;
      if (!in_z[AngW-1]) begin
        out_x <= in_x - y_sh;
        out_y <= in_y + x_sh;
        out_z <= in_z - a;
      end else begin
        out_x <= in_x + y_sh;
        out_y <= in_y - x_sh;
        out_z <= in_z + a;
      end
    end
  end
endmodule

FILE: design/rope_checker.sv
// ----------------------------------------------------------------------------
// Rotary embedding port checker
// Watches the handshake and result codes on the top level ports.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rope_checker (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic signed [15:0] y_even,
  input logic signed [15:0] y_odd,
  input rope_pkg::status_t status
);
  import rope_pkg::*;

  `CHK_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(status),
            "stalled beat changed")
  `CHK_IMPLY(a_code, clk, rst, out_valid, status <= StatusLoad, "bad status code")
  `CHK_IMPLY(a_zero, clk, rst, out_valid && status != StatusOk,
             y_even == 16'sd0 && y_odd == 16'sd0, "nonzero data with error or load")
  `CHK_IMPLY(a_stall, clk, rst, in_stall, out_valid && out_stall,
             "input stalled without output stall")
endmodule

bind rotary_position_embedding_core rope_checker u_rope_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .y_even(y_even), .y_odd(y_odd), .status(status)
);
